// ===== hdl/rss_pkg.sv =====
package rss_pkg;

  localparam int unsigned DEF_WINDOW_DEPTH = 64;
  localparam int unsigned DEF_SAMPLE_WIDTH = 32;

  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned TOTAL_W    = 48;
  localparam int unsigned DEV_W      = 64;
  localparam int unsigned WARMUP_W   = 8;
  localparam int unsigned WINSZ_W    = 7;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_WARMUP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'b1;

  typedef enum logic {
    FUNC_ADD   = 1'b0,
    FUNC_CLEAR = 1'b1
  } func_e;

  typedef struct packed {
    func_e                func;
    logic [SAMPLE_W-1:0]  sample;
  } in_item_t;

  typedef struct packed {
    logic                 in_warmup;
    logic [COUNT_W-1:0]   sample_count;
    logic [TOTAL_W-1:0]   total;
    logic [SAMPLE_W-1:0]  mean;
    logic [DEV_W-1:0]     deviation_sum;
    logic [SAMPLE_W-1:0]  minimum;
    logic [SAMPLE_W-1:0]  maximum;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CUM,
    S_CDIV,
    S_CMUL,
    S_CACC,
    S_WWR,
    S_WSCAN,
    S_OUT
  } state_e;

endpackage

// ===== hdl/rss_stream_if.sv =====
interface rss_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/rss_div.sv =====
module rss_div #(
  parameter int unsigned DIVIDEND_W = 38,
  parameter int unsigned DIVISOR_W  = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  busy_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);
  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [DIVIDEND_W-1:0] dq_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W-1:0]  dvs_q;
  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W:0]    diff;
  logic                  take;

  // one quotient bit per cycle, restoring
  assign rem_sh = {rem_q, dq_q[DIVIDEND_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign take   = ~diff[DIVISOR_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(DIVIDEND_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= take ? diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
      dq_q  <= {dq_q[DIVIDEND_W-2:0], take};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = dq_q;

endmodule

// ===== hdl/running_sample_statistics.sv =====
// Channel  Dir  Payload             Meaning
// req_i    in   rss_pkg::in_item_t  add a sample or clear the statistics
// rsp_o    out  rss_pkg::out_item_t statistics after each request
// cfg_*    in   index, data         warm-up count, window length
//
// Clear and warm-up requests go from idle straight to the output state. A
// cumulative sample after the first runs through the serial divider, one
// quotient bit per cycle. In a window sample the ring is scanned one entry per
// cycle through the single memory read port while the divider runs. Reset
// clears the statistics; the ring needs no clearing. A result waits in the
// output register; the next request is taken meanwhile.
module running_sample_statistics #(
  parameter int unsigned WINDOW_DEPTH = rss_pkg::DEF_WINDOW_DEPTH,
  parameter int unsigned SAMPLE_WIDTH = rss_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rss_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rss_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  rss_stream_if.sink                      req_i,
  rss_stream_if.source                    rsp_o
);
  import rss_pkg::*;

  localparam int unsigned XW   = (SAMPLE_WIDTH < SAMPLE_W) ? SAMPLE_WIDTH : SAMPLE_W;
  localparam int unsigned AW   = $clog2(WINDOW_DEPTH);
  localparam int unsigned LW_D = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned LW   = (LW_D > WINSZ_W) ? LW_D : WINSZ_W;
  localparam int unsigned SUMW = XW + LW;
  localparam int unsigned PW   = 2 * XW;
  localparam int unsigned TW1  = TOTAL_W + 1;
  localparam int unsigned DW1  = DEV_W + 1;

  localparam logic [XW-1:0]      X_ONES    = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
  localparam logic [DEV_W-1:0]   DEV_MAX   = '1;

  state_e state_q, state_d;

  logic [WARMUP_W-1:0] warmup_left_q;
  logic [WINSZ_W-1:0]  window_size_q;
  logic [COUNT_W-1:0]  count_q;
  logic [TOTAL_W-1:0]  sum_q;
  logic [XW-1:0]       mean_q;
  logic [DEV_W-1:0]    dev_q;
  logic [XW-1:0]       min_q;
  logic [XW-1:0]       max_q;
  logic [SUMW-1:0]     wsum_q;
  logic [AW-1:0]       wp_q;
  logic [LW-1:0]       scan_q;
  logic                rd_vld_q;
  logic                warm_q;
  logic                out_valid_q;
  out_item_t           out_q;

  logic [XW-1:0]       x_q;
  logic [XW-1:0]       d1_q;
  logic                dir_q;
  logic [PW-1:0]       prod_q;

  logic [XW-1:0]       win_mem [WINDOW_DEPTH];
  logic [XW-1:0]       rd_data_q;
  logic [AW-1:0]       rd_addr;
  logic                mem_we;

  logic                accept;
  logic                do_clear;
  logic                out_load;
  logic [XW-1:0]       x_in;
  logic [LW-1:0]       win_len;
  logic [COUNT_W-1:0]  count_inc;
  logic                cum_first;
  logic [TW1-1:0]      sum_add;
  logic [TOTAL_W-1:0]  sum_cum;
  logic                x_ge;
  logic [XW-1:0]       d1;
  logic [XW-1:0]       q_mean;
  logic [XW-1:0]       mean_upd;
  logic [XW-1:0]       d2;
  logic [PW-1:0]       prod;
  logic [DW1-1:0]      dev_add;
  logic [DEV_W-1:0]    dev_sat;
  logic                full;
  logic [XW-1:0]       evicted;
  logic [SUMW-1:0]     wsum_new;
  logic [COUNT_W-1:0]  count_win;
  logic [AW-1:0]       wp_next;
  logic [LW-1:0]       cnt_lw;
  logic                issue;
  logic                scan_done;

  logic                div_start;
  logic [SUMW-1:0]     div_dividend;
  logic [COUNT_W-1:0]  div_divisor;
  logic                div_busy;
  logic [SUMW-1:0]     div_quot;

  assign accept   = req_i.valid && req_i.ready;
  assign x_in     = req_i.data.sample[XW-1:0];
  assign do_clear = (accept && req_i.data.func == FUNC_CLEAR) ||
                    (cfg_we_i && cfg_idx_i == REG_WINDOW);

  // window lengths beyond the ring act as the full ring
  assign win_len = (LW'(window_size_q) > LW'(WINDOW_DEPTH)) ? LW'(WINDOW_DEPTH)
                                                            : LW'(window_size_q);

  // cumulative path
  assign count_inc = (count_q == COUNT_MAX) ? count_q : count_q + COUNT_W'(1);
  assign cum_first = (count_q == '0);
  assign sum_add   = {1'b0, sum_q} + TW1'(x_q);
  assign sum_cum   = sum_add[TOTAL_W] ? TOTAL_MAX : sum_add[TOTAL_W-1:0];
  assign x_ge      = (x_q >= mean_q);
  assign d1        = x_ge ? x_q - mean_q : mean_q - x_q;
  assign q_mean    = div_quot[XW-1:0];
  assign mean_upd  = dir_q ? mean_q + q_mean : mean_q - q_mean;
  assign d2        = dir_q ? x_q - mean_q : mean_q - x_q;
  assign prod      = PW'(d1_q) * PW'(d2);
  assign dev_add   = {1'b0, dev_q} + DW1'(prod_q);
  assign dev_sat   = dev_add[DEV_W] ? DEV_MAX : dev_add[DEV_W-1:0];

  // window path: keep the sum incrementally, drop the evicted entry once full
  assign full      = (count_q == COUNT_W'(win_len));
  assign evicted   = full ? rd_data_q : '0;
  assign wsum_new  = wsum_q - SUMW'(evicted) + SUMW'(x_q);
  assign count_win = full ? count_q : count_q + COUNT_W'(1);
  assign wp_next   = (LW'(wp_q) + LW'(1) == win_len) ? '0 : wp_q + AW'(1);
  assign cnt_lw    = count_q[LW-1:0];
  assign issue     = (scan_q < cnt_lw);
  assign scan_done = !issue && !rd_vld_q;

  assign div_dividend = (state_q == S_WWR) ? wsum_new : SUMW'(d1);
  assign div_divisor  = (state_q == S_WWR) ? count_win : count_inc;

  rss_div #(
    .DIVIDEND_W (SUMW),
    .DIVISOR_W  (COUNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quotient_o (div_quot)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_i.data.func == FUNC_CLEAR || warmup_left_q != '0) begin
            state_d = S_OUT;
          end else if (win_len == '0) begin
            state_d = S_CUM;
          end else begin
            state_d = S_WWR;
          end
        end
      end
      S_CUM:   state_d = cum_first ? S_OUT : S_CDIV;
      S_CDIV:  if (!div_busy) state_d = S_CMUL;
      S_CMUL:  state_d = S_CACC;
      S_CACC:  state_d = S_OUT;
      S_WWR:   state_d = S_WSCAN;
      S_WSCAN: if (scan_done && !div_busy) state_d = S_OUT;
      S_OUT:   if (!out_valid_q || rsp_o.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    req_i.ready = 1'b0;
    mem_we      = 1'b0;
    div_start   = 1'b0;
    out_load    = 1'b0;
    rd_addr     = wp_q;
    unique case (state_q)
      S_IDLE:  req_i.ready = 1'b1;
      S_CUM:   div_start = !cum_first;
      S_WWR: begin
        mem_we    = 1'b1;
        div_start = 1'b1;
      end
      S_WSCAN: rd_addr = scan_q[AW-1:0];
      S_OUT:   out_load = !out_valid_q || rsp_o.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warmup_left_q <= '0;
      window_size_q <= '0;
      count_q       <= '0;
      sum_q         <= '0;
      mean_q        <= '0;
      dev_q         <= '0;
      min_q         <= X_ONES;
      max_q         <= '0;
      wsum_q        <= '0;
      wp_q          <= '0;
      scan_q        <= '0;
      rd_vld_q      <= 1'b0;
      warm_q        <= 1'b0;
    end else begin
      rd_vld_q <= (state_q == S_WSCAN) && issue;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_WARMUP: warmup_left_q <= cfg_data_i;
          REG_WINDOW: window_size_q <= cfg_data_i[WINSZ_W-1:0];
          default: ;
        endcase
      end
      if (do_clear) begin
        count_q <= '0;
        sum_q   <= '0;
        mean_q  <= '0;
        dev_q   <= '0;
        min_q   <= X_ONES;
        max_q   <= '0;
        wsum_q  <= '0;
        wp_q    <= '0;
        warm_q  <= 1'b0;
      end else begin
        unique case (state_q)
          S_IDLE: begin
            if (accept) begin
              warm_q <= (warmup_left_q != '0);
              if (warmup_left_q != '0) begin
                warmup_left_q <= warmup_left_q - WARMUP_W'(1);
              end
            end
          end
          S_CUM: begin
            count_q <= count_inc;
            sum_q   <= sum_cum;
            if (cum_first) begin
              mean_q <= x_q;
              min_q  <= x_q;
              max_q  <= x_q;
            end
          end
          S_CDIV: begin
            if (!div_busy) begin
              mean_q <= mean_upd;
            end
          end
          S_CACC: begin
            dev_q <= dev_sat;
            if (x_q < min_q) min_q <= x_q;
            if (x_q > max_q) max_q <= x_q;
          end
          S_WWR: begin
            wsum_q  <= wsum_new;
            sum_q   <= TOTAL_W'(wsum_new);
            count_q <= count_win;
            wp_q    <= wp_next;
            dev_q   <= '0;
            min_q   <= X_ONES;
            max_q   <= '0;
            scan_q  <= '0;
          end
          S_WSCAN: begin
            if (issue) begin
              scan_q <= scan_q + LW'(1);
            end
            if (rd_vld_q) begin
              if (rd_data_q < min_q) min_q <= rd_data_q;
              if (rd_data_q > max_q) max_q <= rd_data_q;
            end
            if (scan_done && !div_busy) begin
              mean_q <= div_quot[XW-1:0];
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= x_in;
    end
    if (state_q == S_CUM) begin
      d1_q  <= d1;
      dir_q <= x_ge;
    end
    if (state_q == S_CMUL) begin
      prod_q <= prod;
    end
  end

  // sample ring
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      win_mem[wp_q] <= x_q;
    end
    rd_data_q <= win_mem[rd_addr];
  end

  // output register: hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.in_warmup     <= warm_q;
      out_q.sample_count  <= count_q;
      out_q.total         <= sum_q;
      out_q.mean          <= SAMPLE_W'(mean_q);
      out_q.deviation_sum <= dev_q;
      out_q.minimum       <= SAMPLE_W'(min_q);
      out_q.maximum       <= SAMPLE_W'(max_q);
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

endmodule

// ===== hdl/rss_checker.sv =====
module rss_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               rsp_valid_i,
  input logic               rsp_ready_i,
  input rss_pkg::out_item_t rsp_data_i
);
  import rss_pkg::*;

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_data_i))
    else $error("result changed while stalled");

  // empty statistics report zero total, mean and maximum
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_data_i.sample_count == '0 |->
      rsp_data_i.total == '0 && rsp_data_i.mean == '0 && rsp_data_i.maximum == '0)
    else $error("empty statistics not zero");

  // mean stays between minimum and maximum
  a_mean_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_data_i.sample_count != '0 |->
      rsp_data_i.minimum <= rsp_data_i.mean && rsp_data_i.mean <= rsp_data_i.maximum)
    else $error("mean outside minimum and maximum");

  // no deviation before a second sample
  a_dev_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_data_i.sample_count < COUNT_W'(2) |->
      rsp_data_i.deviation_sum == '0)
    else $error("deviation sum with fewer than two samples");

endmodule

bind running_sample_statistics rss_checker u_rss_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_data_i  (rsp_o.data)
);
